// ===== src/waveform_block_level_analyzer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block level analyzer
// Implication checks on a clock with a synchronous reset as disable.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_BLOCK_LEVEL_ANALYZER_MACROS_SVH
`define WAVEFORM_BLOCK_LEVEL_ANALYZER_MACROS_SVH

// same-cycle implication
`define WBLK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wblk assertion failed");

// next-cycle implication
`define WBLK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wblk assertion failed");

`endif

// ===== src/wblk_pkg.sv =====
// ----------------------------------------------------------------------------
// Block level analyzer package
// Widths, types, sequencer codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package wblk_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEFF_BITS    = 24;
  localparam int OUT_BITS      = 23;
  localparam int LEN_BITS      = 13;
  localparam int MAX_BLOCK_LEN = 4096;
  localparam int SUM_BITS      = 59;
  localparam int STATE_BITS    = 40;
  localparam int PROD_BITS     = SAMPLE_BITS + COEFF_BITS;
  localparam int FRAC_SHIFT    = COEFF_BITS - 3;
  localparam int RND_IN_BITS   = PROD_BITS + 2;
  localparam int RND_BITS      = RND_IN_BITS - FRAC_SHIFT;
  localparam int NUM_FILT      = 3;
  localparam int NUM_COEF      = 5;
  localparam int NUM_SLOTS     = NUM_FILT * NUM_COEF;
  localparam int NUM_SUMS      = 5;
  localparam int DIV_STEPS     = SUM_BITS;
  localparam int SQRT_STEPS    = (SUM_BITS + 1) / 2;
  localparam int STEP_BITS     = $clog2(DIV_STEPS);
  localparam int OUT_MAX       = (1 << OUT_BITS) - 1;
  localparam int RESET_LEN     = 512;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]  coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [STATE_BITS-1:0]  state_word_t;
  typedef logic signed [RND_IN_BITS-1:0] rnd_in_t;
  typedef logic signed [RND_BITS-1:0]    rnd_t;
  typedef logic signed [STATE_BITS:0]    wide_t;
  typedef logic [SUM_BITS-1:0]           sum_t;
  typedef logic [OUT_BITS-1:0]           mag_t;
  typedef logic [LEN_BITS-1:0]           len_t;
  typedef logic [3:0]                    coef_idx_t;
  typedef logic [2:0]                    coef_slot_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEFF  = 1'b1;

  localparam coef_slot_t SLOT_B0 = 3'd0;
  localparam coef_slot_t SLOT_B1 = 3'd1;
  localparam coef_slot_t SLOT_B2 = 3'd2;
  localparam coef_slot_t SLOT_A1 = 3'd3;
  localparam coef_slot_t SLOT_A2 = 3'd4;

  localparam sum_t SQRT_TOP = SUM_BITS'(1) << (2 * (SQRT_STEPS - 1));

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_RMS, ST_PUSH} top_state_t;

  typedef enum logic [3:0] {
    PH_SQL, PH_SQR, PH_B0, PH_B1, PH_A1, PH_B2, PH_A2, PH_YY, PH_END
  } phase_t;

  typedef enum logic [1:0] {RS_IDLE, RS_DIV, RS_SQRT} rms_state_t;

  typedef struct packed {
    logic start;
    sum_t sum;
    len_t count;
  } rms_req_t;

  typedef struct packed {
    logic done;
    mag_t value;
  } rms_rsp_t;

  function automatic sum_t sat_add(sum_t a, prod_t p);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {{(SUM_BITS + 1 - PROD_BITS){1'b0}}, p};
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

  function automatic rnd_t rnd(rnd_in_t a);
    rnd_in_t t;
    t = a + (RND_IN_BITS'(1) <<< (FRAC_SHIFT - 1));
    return t[RND_IN_BITS-1:FRAC_SHIFT];
  endfunction

  function automatic sample_t sat_sample(wide_t v);
    logic [STATE_BITS-SAMPLE_BITS+1:0] top;
    top = v[STATE_BITS:SAMPLE_BITS-1];
    if (top == '0 || top == '1) return v[SAMPLE_BITS-1:0];
    return v[STATE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  function automatic state_word_t sat_state(wide_t v);
    if (v[STATE_BITS] == v[STATE_BITS-1]) return v[STATE_BITS-1:0];
    return v[STATE_BITS] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
  endfunction

  function automatic mag_t mag(sample_t s);
    logic [SAMPLE_BITS-1:0] a;
    a = s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : s;
    return a[SAMPLE_BITS-1] ? '1 : a[OUT_BITS-1:0];
  endfunction

  function automatic wide_t ext_rnd(rnd_t r);
    return {{(STATE_BITS + 1 - RND_BITS){r[RND_BITS-1]}}, r};
  endfunction

endpackage

// ===== src/wblk_if.sv =====
// ----------------------------------------------------------------------------
// Block level analyzer channels
// Input item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wblk_in_if;
  logic                valid;
  logic                ready;
  logic                op;
  wblk_pkg::sample_t   sample_left;
  wblk_pkg::sample_t   sample_right;
  logic                last_sample;
  wblk_pkg::coef_idx_t coeff_index;
  wblk_pkg::coef_t     coeff_value;

  modport source(output valid, op, sample_left, sample_right, last_sample,
                 coeff_index, coeff_value, input ready);
  modport sink(input valid, op, sample_left, sample_right, last_sample,
               coeff_index, coeff_value, output ready);
endinterface

interface wblk_out_if;
  logic             valid;
  logic             ready;
  wblk_pkg::mag_t   peak_left;
  wblk_pkg::mag_t   peak_right;
  wblk_pkg::mag_t   rms_left;
  wblk_pkg::mag_t   rms_right;
  wblk_pkg::mag_t   energy_low;
  wblk_pkg::mag_t   energy_mid;
  wblk_pkg::mag_t   energy_high;
  logic             final_point;

  modport source(output valid, peak_left, peak_right, rms_left, rms_right,
                 energy_low, energy_mid, energy_high, final_point, input ready);
  modport sink(input valid, peak_left, peak_right, rms_left, rms_right,
               energy_low, energy_mid, energy_high, final_point, output ready);
endinterface

// ===== src/wblk_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed sample-by-coefficient product with a registered output.
// ----------------------------------------------------------------------------
module wblk_mul (
  input  logic              clk,
  input  wblk_pkg::sample_t a,
  input  wblk_pkg::coef_t   b,
  output wblk_pkg::prod_t   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== src/wblk_rms.sv =====
// ----------------------------------------------------------------------------
// Iterative RMS unit
// Restoring divide of a square sum by the sample count, one quotient bit a
// cycle, then a bit-pair square root in place, saturated to 23 bits.
// ----------------------------------------------------------------------------
module wblk_rms (
  input  logic               clk,
  input  logic               rst,
  input  wblk_pkg::rms_req_t req,
  output wblk_pkg::rms_rsp_t rsp
);

  wblk_pkg::rms_state_t         rs, rs_next;
  wblk_pkg::sum_t               d;
  wblk_pkg::len_t               n;
  wblk_pkg::len_t               rem;
  wblk_pkg::sum_t               r;
  wblk_pkg::sum_t               bitm;
  logic [wblk_pkg::STEP_BITS-1:0] step;
  logic [wblk_pkg::LEN_BITS:0]  t_div;
  logic                         div_ge;
  wblk_pkg::len_t               div_rem;
  logic [wblk_pkg::SUM_BITS:0]  t_sq;
  logic                         sq_ge;
  wblk_pkg::sum_t               r_new;
  logic                         div_last;
  logic                         sq_last;

  assign t_div   = {rem, d[wblk_pkg::SUM_BITS-1]};
  assign div_ge  = t_div >= {1'b0, n};
  assign div_rem = div_ge ? wblk_pkg::LEN_BITS'(t_div - {1'b0, n})
                          : t_div[wblk_pkg::LEN_BITS-1:0];
  assign t_sq    = {1'b0, r} + {1'b0, bitm};
  assign sq_ge   = {1'b0, d} >= t_sq;
  assign r_new   = sq_ge ? (r >> 1) + bitm : r >> 1;
  assign div_last = step == wblk_pkg::STEP_BITS'(wblk_pkg::DIV_STEPS - 1);
  assign sq_last  = step == wblk_pkg::STEP_BITS'(wblk_pkg::SQRT_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rs <= wblk_pkg::RS_IDLE;
    end else begin
      rs <= rs_next;
    end
  end

  always_comb begin
    rs_next = rs;
    unique case (rs)
      wblk_pkg::RS_IDLE: if (req.start) rs_next = wblk_pkg::RS_DIV;
      wblk_pkg::RS_DIV:  if (div_last) rs_next = wblk_pkg::RS_SQRT;
      wblk_pkg::RS_SQRT: if (sq_last) rs_next = wblk_pkg::RS_IDLE;
      default:           rs_next = wblk_pkg::RS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (rs)
        wblk_pkg::RS_IDLE: begin
          if (req.start) begin
            d    <= req.sum;
            n    <= req.count;
            rem  <= '0;
            r    <= '0;
            bitm <= wblk_pkg::SQRT_TOP;
            step <= '0;
          end
        end
        wblk_pkg::RS_DIV: begin
          // shift in one quotient bit, d ends up holding the quotient
          d    <= {d[wblk_pkg::SUM_BITS-2:0], div_ge};
          rem  <= div_rem;
          step <= div_last ? '0 : step + 1'b1;
        end
        wblk_pkg::RS_SQRT: begin
          if (sq_ge) d <= d - t_sq[wblk_pkg::SUM_BITS-1:0];
          r    <= r_new;
          bitm <= bitm >> 2;
          step <= step + 1'b1;
          if (sq_last) begin
            rsp.done  <= 1'b1;
            rsp.value <= (r_new > wblk_pkg::SUM_BITS'(wblk_pkg::OUT_MAX))
                         ? '1 : r_new[wblk_pkg::OUT_BITS-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/waveform_block_level_analyzer.sv =====
// ----------------------------------------------------------------------------
// Block level analyzer
// Per-block peak and RMS of a stereo stream plus RMS of three biquad bands.
//
//   channel     | dir | handshake    | content
//   in_item     | in  | valid/ready  | sample pair or coefficient write
//   out_item    | out | valid/ready  | peaks, RMS levels, band energies
//   cfg_write   | in  | write enable | block_length (13 bit)
//
// A coefficient write leaves the input ready. For a sample, one shared
// 24x24 multiplier runs 20 products (two squares, six per biquad) back to back.
// Closing a block adds five divide-and-root passes through the one RMS unit,
// then loads the result into the output registers.
// Synchronous reset clears coefficients, filter state, accumulators and sets
// block_length to 512. A stalled result only holds the loader; a new item is
// taken while the result waits.
// ----------------------------------------------------------------------------
module waveform_block_level_analyzer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  wblk_pkg::len_t cfg_data,
  wblk_in_if.sink        in_item,
  wblk_out_if.source     out_item
);

  wblk_pkg::top_state_t  state, state_next;
  wblk_pkg::phase_t      phase, phase_next;
  logic [1:0]            filt, filt_next;
  wblk_pkg::len_t        block_length;
  wblk_pkg::len_t        cnt;
  wblk_pkg::len_t        cnt_new;
  wblk_pkg::len_t        len_eff;
  logic                  close;
  wblk_pkg::sample_t     l_r, r_r, x_r, y_r;
  logic [wblk_pkg::SAMPLE_BITS:0] lr_sum;
  logic                  last_r;
  wblk_pkg::coef_t       coef [wblk_pkg::NUM_SLOTS];
  wblk_pkg::state_word_t s1 [wblk_pkg::NUM_FILT];
  wblk_pkg::state_word_t s2 [wblk_pkg::NUM_FILT];
  wblk_pkg::mag_t        peak_l, peak_r;
  wblk_pkg::sum_t        sums [wblk_pkg::NUM_SUMS];
  wblk_pkg::mag_t        res [wblk_pkg::NUM_SUMS];
  logic [2:0]            k;
  logic [2:0]            sum_idx;
  wblk_pkg::sum_t        sum_rd;
  wblk_pkg::prod_t       acc;
  wblk_pkg::prod_t       prod;
  wblk_pkg::sample_t     mul_a;
  wblk_pkg::coef_t       mul_b;
  wblk_pkg::coef_slot_t  slot;
  wblk_pkg::coef_idx_t   coef_addr;
  wblk_pkg::rnd_in_t     rnd_in;
  wblk_pkg::rnd_t        rnd_out;
  logic                  rms_busy;
  logic                  rms_start;
  logic                  push;
  logic                  in_acc;
  wblk_pkg::rms_req_t    rms_req;
  wblk_pkg::rms_rsp_t    rms_rsp;
  logic                  out_valid;
  wblk_pkg::mag_t        o_peak_l, o_peak_r, o_rms_l, o_rms_r, o_low, o_mid, o_high;
  logic                  o_final;

  assign in_item.ready = state == wblk_pkg::ST_IDLE;
  assign in_acc        = in_item.valid && in_item.ready;

  assign out_item.valid       = out_valid;
  assign out_item.peak_left   = o_peak_l;
  assign out_item.peak_right  = o_peak_r;
  assign out_item.rms_left    = o_rms_l;
  assign out_item.rms_right   = o_rms_r;
  assign out_item.energy_low  = o_low;
  assign out_item.energy_mid  = o_mid;
  assign out_item.energy_high = o_high;
  assign out_item.final_point = o_final;

  // floor((L+R)/2) always fits 24 bits
  assign lr_sum = {l_r[wblk_pkg::SAMPLE_BITS-1], l_r} + {r_r[wblk_pkg::SAMPLE_BITS-1], r_r};

  assign cnt_new = cnt + 1'b1;
  assign len_eff = (block_length == '0) ? wblk_pkg::LEN_BITS'(1)
                 : (block_length > wblk_pkg::LEN_BITS'(wblk_pkg::MAX_BLOCK_LEN))
                   ? wblk_pkg::LEN_BITS'(wblk_pkg::MAX_BLOCK_LEN) : block_length;
  assign close = last_r || (cnt_new >= len_eff);

  // operand select for the shared multiplier
  always_comb begin
    slot  = wblk_pkg::SLOT_B0;
    mul_a = x_r;
    unique case (phase)
      wblk_pkg::PH_SQL: mul_a = l_r;
      wblk_pkg::PH_SQR: mul_a = r_r;
      wblk_pkg::PH_B0:  slot = wblk_pkg::SLOT_B0;
      wblk_pkg::PH_B1:  slot = wblk_pkg::SLOT_B1;
      wblk_pkg::PH_A1: begin
        slot  = wblk_pkg::SLOT_A1;
        mul_a = y_r;
      end
      wblk_pkg::PH_B2:  slot = wblk_pkg::SLOT_B2;
      wblk_pkg::PH_A2: begin
        slot  = wblk_pkg::SLOT_A2;
        mul_a = y_r;
      end
      wblk_pkg::PH_YY:  mul_a = y_r;
      wblk_pkg::PH_END: mul_a = '0;
      default:          mul_a = '0;
    endcase
  end

  assign coef_addr = 4'(filt) * 4'(wblk_pkg::NUM_COEF) + {1'b0, slot};

  always_comb begin
    mul_b = coef[coef_addr];
    case (phase)
      wblk_pkg::PH_SQL: mul_b = l_r;
      wblk_pkg::PH_SQR: mul_b = r_r;
      wblk_pkg::PH_YY:  mul_b = y_r;
      default:          mul_b = coef[coef_addr];
    endcase
  end

  wblk_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    if (phase == wblk_pkg::PH_B1) begin
      rnd_in = {{2{prod[wblk_pkg::PROD_BITS-1]}}, prod};
    end else begin
      rnd_in = {{2{acc[wblk_pkg::PROD_BITS-1]}}, acc} - {{2{prod[wblk_pkg::PROD_BITS-1]}}, prod};
    end
  end
  assign rnd_out = wblk_pkg::rnd(rnd_in);

  // one accumulator address at a time
  always_comb begin
    if (state == wblk_pkg::ST_RMS) begin
      sum_idx = k;
    end else if (phase == wblk_pkg::PH_SQR) begin
      sum_idx = 3'd0;
    end else if (phase == wblk_pkg::PH_END) begin
      sum_idx = 3'(wblk_pkg::NUM_SUMS - 1);
    end else begin
      sum_idx = {1'b0, filt} + 3'd1;
    end
  end
  assign sum_rd = sums[sum_idx];

  assign rms_req.start = rms_start;
  assign rms_req.sum   = sum_rd;
  assign rms_req.count = cnt;

  wblk_rms u_rms (
    .clk (clk),
    .rst (rst),
    .req (rms_req),
    .rsp (rms_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wblk_pkg::ST_IDLE;
      phase <= wblk_pkg::PH_SQL;
      filt  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      filt  <= filt_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    filt_next  = filt;
    rms_start  = 1'b0;
    push       = 1'b0;
    unique case (state)
      wblk_pkg::ST_IDLE: begin
        if (in_acc && in_item.op == wblk_pkg::OP_SAMPLE) begin
          state_next = wblk_pkg::ST_MAC;
          phase_next = wblk_pkg::PH_SQL;
          filt_next  = '0;
        end
      end
      wblk_pkg::ST_MAC: begin
        unique case (phase)
          wblk_pkg::PH_SQL: phase_next = wblk_pkg::PH_SQR;
          wblk_pkg::PH_SQR: phase_next = wblk_pkg::PH_B0;
          wblk_pkg::PH_B0:  phase_next = wblk_pkg::PH_B1;
          wblk_pkg::PH_B1:  phase_next = wblk_pkg::PH_A1;
          wblk_pkg::PH_A1:  phase_next = wblk_pkg::PH_B2;
          wblk_pkg::PH_B2:  phase_next = wblk_pkg::PH_A2;
          wblk_pkg::PH_A2:  phase_next = wblk_pkg::PH_YY;
          wblk_pkg::PH_YY: begin
            if (filt == 2'(wblk_pkg::NUM_FILT - 1)) begin
              phase_next = wblk_pkg::PH_END;
            end else begin
              phase_next = wblk_pkg::PH_B0;
              filt_next  = filt + 1'b1;
            end
          end
          wblk_pkg::PH_END: begin
            phase_next = wblk_pkg::PH_SQL;
            state_next = close ? wblk_pkg::ST_RMS : wblk_pkg::ST_IDLE;
          end
          default: phase_next = wblk_pkg::PH_SQL;
        endcase
      end
      wblk_pkg::ST_RMS: begin
        if (!rms_busy) begin
          rms_start = 1'b1;
        end else if (rms_rsp.done && k == 3'(wblk_pkg::NUM_SUMS - 1)) begin
          state_next = wblk_pkg::ST_PUSH;
        end
      end
      wblk_pkg::ST_PUSH: begin
        if (!out_valid || out_item.ready) begin
          push       = 1'b1;
          state_next = wblk_pkg::ST_IDLE;
        end
      end
      default: state_next = wblk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= wblk_pkg::LEN_BITS'(wblk_pkg::RESET_LEN);
      cnt          <= '0;
      peak_l       <= '0;
      peak_r       <= '0;
      rms_busy     <= 1'b0;
      k            <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < wblk_pkg::NUM_SLOTS; i++) coef[i] <= '0;
      for (int i = 0; i < wblk_pkg::NUM_FILT; i++) begin
        s1[i] <= '0;
        s2[i] <= '0;
      end
      for (int i = 0; i < wblk_pkg::NUM_SUMS; i++) sums[i] <= '0;
    end else begin
      if (cfg_write) block_length <= cfg_data;

      if (in_acc) begin
        if (in_item.op == wblk_pkg::OP_COEFF) begin
          // the top index is not a slot: drop the write
          if (in_item.coeff_index < 4'(wblk_pkg::NUM_SLOTS)) begin
            coef[in_item.coeff_index] <= in_item.coeff_value;
          end
        end else begin
          l_r    <= in_item.sample_left;
          r_r    <= in_item.sample_right;
          last_r <= in_item.last_sample;
        end
      end

      if (state == wblk_pkg::ST_MAC) begin
        case (phase)
          wblk_pkg::PH_SQL: begin
            if (wblk_pkg::mag(l_r) > peak_l) peak_l <= wblk_pkg::mag(l_r);
            if (wblk_pkg::mag(r_r) > peak_r) peak_r <= wblk_pkg::mag(r_r);
            x_r <= lr_sum[wblk_pkg::SAMPLE_BITS:1];
          end
          wblk_pkg::PH_SQR, wblk_pkg::PH_B0: sums[sum_idx] <= wblk_pkg::sat_add(sum_rd, prod);
          wblk_pkg::PH_B1: begin
            y_r <= wblk_pkg::sat_sample(wblk_pkg::ext_rnd(rnd_out)
                   + {s1[filt][wblk_pkg::STATE_BITS-1], s1[filt]});
          end
          wblk_pkg::PH_A1, wblk_pkg::PH_A2: acc <= prod;
          wblk_pkg::PH_B2: begin
            s1[filt] <= wblk_pkg::sat_state(wblk_pkg::ext_rnd(rnd_out)
                        + {s2[filt][wblk_pkg::STATE_BITS-1], s2[filt]});
          end
          wblk_pkg::PH_YY: begin
            s2[filt] <= wblk_pkg::sat_state(wblk_pkg::ext_rnd(rnd_out));
          end
          wblk_pkg::PH_END: begin
            sums[sum_idx] <= wblk_pkg::sat_add(sum_rd, prod);
            cnt           <= cnt_new;
          end
          default: ;
        endcase
      end

      if (rms_start) rms_busy <= 1'b1;
      if (rms_rsp.done) begin
        rms_busy <= 1'b0;
        res[k]   <= rms_rsp.value;
        k        <= k + 1'b1;
      end

      out_valid <= push || (out_valid && !out_item.ready);

      if (push) begin
        o_peak_l  <= peak_l;
        o_peak_r  <= peak_r;
        o_rms_l   <= res[0];
        o_rms_r   <= res[1];
        o_low     <= res[2];
        o_mid     <= res[3];
        o_high    <= rms_rsp.value;
        o_final   <= last_r;
        // open a fresh block
        peak_l    <= '0;
        peak_r    <= '0;
        cnt       <= '0;
        k         <= '0;
        for (int i = 0; i < wblk_pkg::NUM_SUMS; i++) sums[i] <= '0;
        if (last_r) begin
          for (int i = 0; i < wblk_pkg::NUM_FILT; i++) begin
            s1[i] <= '0;
            s2[i] <= '0;
          end
        end
      end
    end
  end

endmodule

// ===== src/wblk_checker.sv =====
// ----------------------------------------------------------------------------
// Block level analyzer port checker
// Watches the top level's ports for sequencing and result hold rules.
// ----------------------------------------------------------------------------
`include "waveform_block_level_analyzer_macros.svh"

module wblk_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_op,
  input logic           out_valid,
  input logic           out_ready,
  input wblk_pkg::mag_t out_peak_left,
  input logic           out_final
);

  `WBLK_ASSERT_NEXT(a_sample_busy, clk, rst, in_valid && in_ready && in_op == wblk_pkg::OP_SAMPLE, !in_ready)
  `WBLK_ASSERT_NEXT(a_coeff_ready, clk, rst, in_valid && in_ready && in_op == wblk_pkg::OP_COEFF, in_ready)
  `WBLK_ASSERT_NOW(a_result_after_busy, clk, rst, $rose(out_valid), !$past(in_ready))
  `WBLK_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_peak_left) && $stable(out_final))

endmodule

bind waveform_block_level_analyzer wblk_checker u_wblk_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .in_op         (in_item.op),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .out_peak_left (out_item.peak_left),
  .out_final     (out_item.final_point)
);
